FILE: sv/gsp_pkg.sv
// Shared types and constants of the grid smoothness penalty unit.
package gsp_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SIZE_W     = 11;
   localparam int WEIGHT_W   = 16;
   localparam int SUM_W      = 64;
   localparam int SQ_W       = 2 * SAMPLE_W;
   localparam int HALF_W     = SUM_W / 2;
   localparam int PROD_W     = HALF_W + WEIGHT_W;
   localparam int PEN_SUM_W  = SUM_W + WEIGHT_W + 2;
   localparam int PEN_SHIFT  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 1024;

   localparam logic [SIZE_W-1:0]   ROWS_RESET   = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0]   COLS_RESET   = SIZE_W'(1024);
   localparam logic [WEIGHT_W-1:0] LAMBDA_RESET = WEIGHT_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS = 2'd0,
      CSR_GRID_COLS = 2'd1,
      CSR_LAMBDA_X  = 2'd2,
      CSR_LAMBDA_Z  = 2'd3
   } gsp_csr_type;

   typedef enum logic [1:0] {
      FIN_IDLE,
      FIN_MUL,
      FIN_OUT
   } gsp_fin_state_type;

   // per-beat control travelling with a sample
   typedef struct packed {
      logic do_v;
      logic do_h;
      logic last;
   } gsp_beat_type;

   // grid totals handed to the finisher
   typedef struct packed {
      logic [SUM_W-1:0] sum_h;
      logic [SUM_W-1:0] sum_v;
   } gsp_total_type;

endpackage

FILE: sv/gsp_req_if.sv
// Input sample channel.
interface gsp_req_if import gsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

FILE: sv/gsp_rsp_if.sv
// Result channel.
interface gsp_rsp_if import gsp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] penalty;
   logic [SUM_W-1:0] sum_horizontal;
   logic [SUM_W-1:0] sum_vertical;

   modport source (output valid, penalty, sum_horizontal, sum_vertical, input ready);
   modport sink   (input valid, penalty, sum_horizontal, sum_vertical, output ready);
endinterface

FILE: sv/gsp_csr_if.sv
// Register write channel.
interface gsp_csr_if import gsp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/grid_smoothness_penalty_unit.sv
// Grid smoothness penalty unit: top level with counters and register file.
//
// Usage: grid samples stream in on req_bus, column by column, row index
// fastest. Each beat is one 16-bit sample. After the last sample of the
// grid one beat leaves on rsp_bus with the weighted penalty and both raw
// saturated sums; every other sample produces nothing.
// csr_bus writes grid_rows, grid_cols, lambda_x and lambda_z (index 0..3);
// it is always ready and must only be used while the block is idle.
// Throughput: one sample per cycle, except while a grid's last sample is
// held off; set by the single line store port (one read and one write of
// the same row each cycle). The result beat follows the last sample
// through two pipeline stages, the accumulator stage, the handoff and five
// steps of the shared 32x16 multiplier that forms the weighted penalty.
// Receiver stall: the result sits in the finisher's output register; the
// next grid keeps streaming, only its last sample is held off while the
// previous result is still waiting.
// Reset: synchronous, active high; counters, sums and the result path
// clear, registers return to 1024 x 1024 with both weights at 1.0. The
// line store has no reset and needs no clearing pass.
module grid_smoothness_penalty_unit import gsp_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic      clock,
   input  logic      reset,
   gsp_req_if.sink   req_bus,
   gsp_rsp_if.source rsp_bus,
   gsp_csr_if.sink   csr_bus
);

   localparam int RW  = $clog2(MAX_ROWS);       // row counter / store address
   localparam int RCW = $clog2(MAX_ROWS + 1);   // row count incl. MAX_ROWS
   localparam int CW  = $clog2(MAX_COLS);
   localparam int CCW = $clog2(MAX_COLS + 1);

   // register file
   logic [SIZE_W-1:0]   rows_ff;
   logic [SIZE_W-1:0]   cols_ff;
   logic [WEIGHT_W-1:0] lambda_x_ff;
   logic [WEIGHT_W-1:0] lambda_z_ff;

   // grid position and previous sample
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [SAMPLE_W-1:0] prev_ff;
   logic                pending_ff;     // result of a finished grid not yet taken

   logic [RCW-1:0]      eff_rows;
   logic [CCW-1:0]      eff_cols;
   logic [RCW-1:0]      row_inc;
   logic [CCW-1:0]      col_inc;
   logic                row_end;
   logic                col_end;
   logic                is_last;
   logic                accept;
   logic                rsp_taken;
   gsp_beat_type        beat;
   logic [SAMPLE_W-1:0] store_rdata;
   logic                done_valid;
   gsp_total_type       done_total;

   // --- register writes ---------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= ROWS_RESET;
         cols_ff     <= COLS_RESET;
         lambda_x_ff <= LAMBDA_RESET;
         lambda_z_ff <= LAMBDA_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_GRID_ROWS: rows_ff     <= csr_bus.data[SIZE_W-1:0];
            CSR_GRID_COLS: cols_ff     <= csr_bus.data[SIZE_W-1:0];
            CSR_LAMBDA_X:  lambda_x_ff <= csr_bus.data[WEIGHT_W-1:0];
            CSR_LAMBDA_Z:  lambda_z_ff <= csr_bus.data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // --- effective grid size: zero acts as one, clamp to the store size ----
   always_comb begin
      if (rows_ff == '0) begin
         eff_rows = RCW'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         eff_rows = RCW'(MAX_ROWS);
      end else begin
         eff_rows = RCW'(rows_ff);
      end
      if (cols_ff == '0) begin
         eff_cols = CCW'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         eff_cols = CCW'(MAX_COLS);
      end else begin
         eff_cols = CCW'(cols_ff);
      end
   end

   // --- position tracking; ends use >= so a shrunk size ends promptly ------
   always_comb begin
      row_inc = RCW'(row_ff) + RCW'(1);
      col_inc = CCW'(col_ff) + CCW'(1);
      row_end = (row_inc >= eff_rows);
      col_end = (col_inc >= eff_cols);
      is_last = row_end && col_end;
      row_in  = row_end ? '0 : row_inc[RW-1:0];
      col_in  = col_ff;
      if (row_end) begin
         col_in = col_end ? '0 : col_inc[CW-1:0];
      end
   end

   // last sample waits while a previous result is still outstanding
   assign req_bus.ready = !(pending_ff && is_last);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_taken     = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         prev_ff    <= '0;
         pending_ff <= 1'b0;
      end else begin
         if (accept) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            prev_ff <= req_bus.sample;
         end
         if (accept && is_last) begin
            pending_ff <= 1'b1;
         end else if (rsp_taken) begin
            pending_ff <= 1'b0;
         end
      end
   end

   // no vertical term on row 0, no horizontal term on column 0
   always_comb begin
      beat.do_v = (row_ff != '0);
      beat.do_h = (col_ff != '0);
      beat.last = is_last;
   end

   // --- datapath -----------------------------------------------------------
   gsp_line_store #(
      .DEPTH (MAX_ROWS)
   ) u_store (
      .clock (clock),
      .wr_en (accept),
      .addr  (row_ff),
      .wdata (req_bus.sample),
      .rdata (store_rdata)
   );

   gsp_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_beat     (beat),
      .in_sample   (req_bus.sample),
      .in_prev     (prev_ff),
      .store_rdata (store_rdata),
      .done_valid  (done_valid),
      .done_total  (done_total)
   );

   gsp_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .start    (done_valid),
      .total    (done_total),
      .lambda_x (lambda_x_ff),
      .lambda_z (lambda_z_ff),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: sv/gsp_line_store.sv
// Column line store: one write and one read-first read per cycle.
module gsp_line_store import gsp_pkg::*; #(
   parameter int DEPTH = DEF_MAX_ROWS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [SAMPLE_W-1:0]      wdata,
   output logic [SAMPLE_W-1:0]      rdata
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff;

   // read returns the entry as it was before this cycle's write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/gsp_accum.sv
// Difference squaring and saturating accumulation of both sums.
module gsp_accum import gsp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  gsp_beat_type        in_beat,
   input  logic [SAMPLE_W-1:0] in_sample,
   input  logic [SAMPLE_W-1:0] in_prev,
   input  logic [SAMPLE_W-1:0] store_rdata,
   output logic                done_valid,
   output gsp_total_type       done_total
);

   // stage 1: sample, neighbors
   logic                s1_vld_ff;
   gsp_beat_type        s1_beat_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [SAMPLE_W-1:0] s1_prev_ff;
   // stage 2: squares
   logic                s2_vld_ff;
   logic                s2_last_ff;
   logic [SQ_W-1:0]     s2_sq_h_ff;
   logic [SQ_W-1:0]     s2_sq_v_ff;
   logic [SQ_W-1:0]     s2_sq_h_in;
   logic [SQ_W-1:0]     s2_sq_v_in;
   // accumulators and handoff
   logic [SUM_W-1:0]    acc_h_ff;
   logic [SUM_W-1:0]    acc_v_ff;
   logic [SUM_W-1:0]    acc_h_in;
   logic [SUM_W-1:0]    acc_v_in;
   logic                done_ff;
   gsp_total_type       total_ff;

   logic [SAMPLE_W-1:0] diff_h;
   logic [SAMPLE_W-1:0] diff_v;
   logic [SUM_W:0]      add_h;
   logic [SUM_W:0]      add_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_beat_ff   <= in_beat;
      s1_sample_ff <= in_sample;
      s1_prev_ff   <= in_prev;
      s2_last_ff   <= s1_beat_ff.last;
      s2_sq_h_ff   <= s2_sq_h_in;
      s2_sq_v_ff   <= s2_sq_v_in;
   end

   always_comb begin
      diff_h = (s1_sample_ff >= store_rdata) ? (s1_sample_ff - store_rdata)
                                             : (store_rdata - s1_sample_ff);
      diff_v = (s1_sample_ff >= s1_prev_ff) ? (s1_sample_ff - s1_prev_ff)
                                            : (s1_prev_ff - s1_sample_ff);
      s2_sq_h_in = s1_beat_ff.do_h ? (SQ_W'(diff_h) * SQ_W'(diff_h)) : '0;
      s2_sq_v_in = s1_beat_ff.do_v ? (SQ_W'(diff_v) * SQ_W'(diff_v)) : '0;
   end

   always_comb begin
      add_h = {1'b0, acc_h_ff} + (SUM_W + 1)'(s2_sq_h_ff);
      add_v = {1'b0, acc_v_ff} + (SUM_W + 1)'(s2_sq_v_ff);
      acc_h_in = add_h[SUM_W] ? '1 : add_h[SUM_W-1:0];
      acc_v_in = add_v[SUM_W] ? '1 : add_v[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_h_ff <= '0;
         acc_v_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= s2_vld_ff && s2_last_ff;
         if (s2_vld_ff) begin
            // last beat of a grid: hand totals over, restart from zero
            acc_h_ff <= s2_last_ff ? '0 : acc_h_in;
            acc_v_ff <= s2_last_ff ? '0 : acc_v_in;
         end
      end
      if (s2_vld_ff && s2_last_ff) begin
         total_ff.sum_h <= acc_h_in;
         total_ff.sum_v <= acc_v_in;
      end
   end

   assign done_valid = done_ff;
   assign done_total = total_ff;

endmodule

FILE: sv/gsp_finish.sv
// Weighted penalty sequencer and result register.
module gsp_finish import gsp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  gsp_total_type       total,
   input  logic [WEIGHT_W-1:0] lambda_x,
   input  logic [WEIGHT_W-1:0] lambda_z,
   gsp_rsp_if.source           rsp_bus
);

   localparam int STEPS = 4;
   localparam int STEP_W = $clog2(STEPS + 1);

   gsp_fin_state_type     state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   gsp_total_type         tot_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  prod_hi_ff;
   logic [PEN_SUM_W-1:0]  sum_ff;
   logic [HALF_W-1:0]     mul_a;
   logic [WEIGHT_W-1:0]   mul_w;
   logic [SUM_W-1:0]      mul_src;
   logic [PEN_SUM_W-1:0]  prod_aligned;
   logic [SUM_W-1:0]      penalty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIN_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         FIN_IDLE: begin
            if (start) begin
               state_in = FIN_MUL;
               step_in  = '0;
            end
         end
         FIN_MUL: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS)) begin
               state_in = FIN_OUT;
            end
         end
         FIN_OUT: begin
            if (rsp_bus.ready) begin
               state_in = FIN_IDLE;
            end
         end
         default: state_in = FIN_IDLE;
      endcase
   end

   // step bit 1 picks the sum, bit 0 the 32-bit half
   always_comb begin
      mul_src = step_ff[1] ? tot_ff.sum_v : tot_ff.sum_h;
      mul_w   = step_ff[1] ? lambda_z : lambda_x;
      mul_a   = step_ff[0] ? mul_src[SUM_W-1:HALF_W] : mul_src[HALF_W-1:0];
      prod_aligned = prod_hi_ff ? (PEN_SUM_W'(prod_ff) << HALF_W) : PEN_SUM_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == FIN_IDLE && start) begin
         tot_ff <= total;
         sum_ff <= '0;
      end
      if (state_ff == FIN_MUL) begin
         prod_ff    <= PROD_W'(mul_a) * PROD_W'(mul_w);
         prod_hi_ff <= step_ff[0];
         if (step_ff != '0) begin
            sum_ff <= sum_ff + prod_aligned;
         end
      end
   end

   always_comb begin
      if (sum_ff[PEN_SUM_W-1:SUM_W+PEN_SHIFT] != '0) begin
         penalty = '1;
      end else begin
         penalty = sum_ff[SUM_W+PEN_SHIFT-1:PEN_SHIFT];
      end
   end

   assign rsp_bus.valid          = (state_ff == FIN_OUT);
   assign rsp_bus.penalty        = penalty;
   assign rsp_bus.sum_horizontal = tot_ff.sum_h;
   assign rsp_bus.sum_vertical   = tot_ff.sum_v;

endmodule
